// File: rtl/core/rhc_pkg.sv
package rhc_pkg;

   localparam int CH_BITS = 16;
   localparam logic [CH_BITS-1:0] CH_FULL = '1;

   localparam int DIV_STAGES = 17;
   localparam int NUM_BITS = 36;
   localparam int DEN_BITS = 20;
   localparam int QUO_BITS = DIV_STAGES;

   localparam int HSX_STAGES = 6;
   localparam int FRONT_STAGES = 2;
   localparam int HSX_DELAY = DIV_STAGES + FRONT_STAGES - HSX_STAGES;
   localparam int PIPE_LEN = DIV_STAGES + FRONT_STAGES + 1;

   typedef enum logic [1:0] {
      FUNC_RGB2HSV = 2'd0,
      FUNC_HSV2RGB = 2'd1,
      FUNC_RGB2HSL = 2'd2,
      FUNC_HSL2RGB = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic               hue_zero;
      logic               sat_zero;
      logic [CH_BITS-1:0] val;
   } div_tag_type;

   // Rounded division by full scale, saturated to the channel range.
   function automatic logic [15:0] div_full_round(input logic [33:0] x);
      logic [34:0] z;
      logic [18:0] q1;
      logic [19:0] r1;
      logic [3:0]  q2;
      logic [16:0] r2;
      logic [18:0] q;
      z  = {1'b0, x} + 35'd32767;
      q1 = z[34:16];
      r1 = {4'b0, z[15:0]} + {1'b0, q1};
      q2 = r1[19:16];
      r2 = {1'b0, r1[15:0]} + {13'b0, q2};
      q  = q1 + {15'b0, q2} + ((r2 >= 17'd65535) ? 19'd1 : 19'd0);
      return (q > 19'd65535) ? 16'hFFFF : q[15:0];
   endfunction

endpackage

// File: rtl/core/rhc_rgb.sv
module rhc_rgb (
   input  logic                                 clock,
   input  logic                                 ce,
   input  rhc_pkg::func_type                    func,
   input  logic [15:0]                          chan_a,
   input  logic [15:0]                          chan_b,
   input  logic [15:0]                          chan_c,
   output logic [1:0][rhc_pkg::NUM_BITS-1:0]    num,
   output logic [1:0][rhc_pkg::DEN_BITS-1:0]    den,
   output rhc_pkg::div_tag_type                 tag
);

   logic [15:0] mx, mn, d;
   logic [18:0] t;
   logic [16:0] sum, rest, lim;

   rhc_pkg::func_type func_ff;
   logic [15:0] mx_ff, d_ff;
   logic [18:0] t_ff;
   logic [16:0] sum_ff, lim_ff;

   logic [1:0][rhc_pkg::NUM_BITS-1:0] num_in, num_ff;
   logic [1:0][rhc_pkg::DEN_BITS-1:0] den_in, den_ff;
   rhc_pkg::div_tag_type tag_in, tag_ff;
   logic        hsv;
   logic [16:0] base, sum_p1;
   logic [31:0] df;

   always_comb begin
      mx = chan_a;
      if (chan_b > mx) mx = chan_b;
      if (chan_c > mx) mx = chan_c;
      mn = chan_a;
      if (chan_b < mn) mn = chan_b;
      if (chan_c < mn) mn = chan_c;
      d = mx - mn;
      if (chan_a >= chan_b && chan_a >= chan_c) begin
         if (chan_b >= chan_c) t = {3'b0, chan_b - chan_c};
         else t = ({3'b0, d} * 19'd6) - {3'b0, chan_c - chan_b};
      end else if (chan_b >= chan_c) begin
         t = ({3'b0, chan_c} + ({3'b0, d} << 1)) - {3'b0, chan_a};
      end else begin
         t = ({3'b0, chan_a} + ({3'b0, d} << 2)) - {3'b0, chan_b};
      end
      sum  = {1'b0, mx} + {1'b0, mn};
      rest = 17'h1FFFE - sum;
      lim  = (sum < rest) ? sum : rest;
   end

   always_comb begin
      hsv    = (func_ff == rhc_pkg::FUNC_RGB2HSV);
      base   = hsv ? {1'b0, mx_ff} : lim_ff;
      sum_p1 = sum_ff + 17'd1;
      df     = {d_ff, 16'b0} - {16'b0, d_ff};
      num_in[0] = {t_ff, 17'b0} + rhc_pkg::NUM_BITS'({d_ff, 3'b0} - {2'b0, d_ff, 1'b0});
      den_in[0] = rhc_pkg::DEN_BITS'({d_ff, 4'b0} - {2'b0, d_ff, 2'b0});
      num_in[1] = rhc_pkg::NUM_BITS'({df, 1'b0}) + rhc_pkg::NUM_BITS'(base);
      den_in[1] = rhc_pkg::DEN_BITS'({base, 1'b0});
      tag_in.func     = func_ff;
      tag_in.hue_zero = (d_ff == 16'd0);
      tag_in.sat_zero = (base == 17'd0);
      tag_in.val      = hsv ? mx_ff : sum_p1[16:1];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         func_ff <= func;
         mx_ff   <= mx;
         d_ff    <= d;
         t_ff    <= t;
         sum_ff  <= sum;
         lim_ff  <= lim;
         num_ff  <= num_in;
         den_ff  <= den_in;
         tag_ff  <= tag_in;
      end
   end

   assign num = num_ff;
   assign den = den_ff;
   assign tag = tag_ff;

endmodule

// File: rtl/core/rhc_div.sv
module rhc_div (
   input  logic                                 clock,
   input  logic                                 ce,
   input  logic [1:0][rhc_pkg::NUM_BITS-1:0]    num,
   input  logic [1:0][rhc_pkg::DEN_BITS-1:0]    den,
   input  rhc_pkg::div_tag_type                 tag,
   output logic [1:0][rhc_pkg::QUO_BITS-1:0]    quo,
   output rhc_pkg::div_tag_type                 tag_out
);

   localparam int S = rhc_pkg::DIV_STAGES;

   logic [1:0][rhc_pkg::NUM_BITS-1:0] rem_ff [S];
   logic [1:0][rhc_pkg::NUM_BITS-1:0] rem_in [S];
   logic [1:0][rhc_pkg::DEN_BITS-1:0] den_ff [S];
   logic [1:0][rhc_pkg::DEN_BITS-1:0] den_in [S];
   logic [1:0][rhc_pkg::QUO_BITS-1:0] quo_ff [S];
   logic [1:0][rhc_pkg::QUO_BITS-1:0] quo_in [S];
   rhc_pkg::div_tag_type              tag_ff [S];
   rhc_pkg::div_tag_type              tag_in [S];

   always_comb begin
      for (int s = 0; s < S; s++) begin
         tag_in[s] = (s == 0) ? tag : tag_ff[(s == 0) ? 0 : s - 1];
         for (int l = 0; l < 2; l++) begin
            logic [rhc_pkg::NUM_BITS-1:0] r_prev, cand;
            logic [rhc_pkg::QUO_BITS-1:0] q_prev;
            r_prev = (s == 0) ? num[l] : rem_ff[(s == 0) ? 0 : s - 1][l];
            q_prev = (s == 0) ? '0 : quo_ff[(s == 0) ? 0 : s - 1][l];
            den_in[s][l] = (s == 0) ? den[l] : den_ff[(s == 0) ? 0 : s - 1][l];
            cand = rhc_pkg::NUM_BITS'(den_in[s][l]) << (S - 1 - s);
            if (r_prev >= cand) begin
               rem_in[s][l] = r_prev - cand;
               quo_in[s][l] = q_prev | (rhc_pkg::QUO_BITS'(1) << (S - 1 - s));
            end else begin
               rem_in[s][l] = r_prev;
               quo_in[s][l] = q_prev;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
         tag_ff <= tag_in;
      end
   end

   assign quo     = quo_ff[S-1];
   assign tag_out = tag_ff[S-1];

endmodule

// File: rtl/core/rhc_hsx.sv
module rhc_hsx (
   input  logic                clock,
   input  logic                ce,
   input  rhc_pkg::func_type   func,
   input  logic [15:0]         chan_a,
   input  logic [15:0]         chan_b,
   input  logic [15:0]         chan_c,
   output logic [2:0][15:0]    res
);

   localparam logic [2:0] OFFS [3] = '{3'd0, 3'd4, 3'd2};

   function automatic logic [16:0] tri_wave(input logic [15:0] h, input logic [2:0] off);
      logic [19:0] p, dd, fn;
      p = ({4'b0, h} * 20'd6) + {1'b0, off, 16'b0};
      if (p >= 20'd393216) p = p - 20'd393216;
      dd = (p > 20'd196608) ? p - 20'd196608 : 20'd196608 - p;
      fn = (dd > 20'd65536) ? dd - 20'd65536 : 20'd0;
      if (fn > 20'd65536) fn = 20'd65536;
      return fn[16:0];
   endfunction

   rhc_pkg::func_type f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   logic [16:0] fn1_ff [3], fn2_ff [3], fn3_ff [3];
   logic [15:0] span1_ff, b1_ff, c1_ff, b2_ff, c2_ff, c3_ff, c4_ff;
   logic [15:0] cs2_ff [3];
   logic [31:0] pc2_ff;
   logic [31:0] pm3_ff [3];
   logic [15:0] chroma3_ff;
   logic [15:0] m4_ff [3];
   logic signed [35:0] ph4_ff [3];
   logic [31:0] pv5_ff [3];
   logic [15:0] hl5_ff [3];
   logic [2:0][15:0] res_ff;

   logic [16:0] fn1_in [3];
   logic [16:0] c2x, dev;
   logic [15:0] span1_in;
   logic [15:0] cs2_in [3];
   logic [31:0] pm3_in [3];
   logic [15:0] m4_in [3];
   logic signed [35:0] ph4_in [3];
   logic [31:0] pv5_in [3];
   logic [15:0] hl5_in [3];
   logic [2:0][15:0] res_in;

   always_comb begin
      for (int k = 0; k < 3; k++) fn1_in[k] = tri_wave(chan_a, OFFS[k]);
      c2x = {chan_c, 1'b0};
      dev = (c2x > 17'h0FFFF) ? c2x - 17'h0FFFF : 17'h0FFFF - c2x;
      span1_in = (dev > 17'h0FFFF) ? 16'd0 : rhc_pkg::CH_FULL - dev[15:0];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [32:0] t33;
         t33 = {fn1_ff[k], 16'b0} - {16'b0, fn1_ff[k]} + 33'd32768;
         cs2_in[k] = (t33[32:16] > 17'h0FFFF) ? 16'hFFFF : t33[31:16];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) pm3_in[k] = b2_ff * (rhc_pkg::CH_FULL - cs2_ff[k]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [18:0] w;
         m4_in[k]  = rhc_pkg::div_full_round({2'b0, pm3_ff[k]});
         w         = $signed({1'b0, fn3_ff[k], 1'b0}) - 19'sd65536;
         ph4_in[k] = $signed({1'b0, chroma3_ff}) * w;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [36:0] n;
         pv5_in[k] = c4_ff * (rhc_pkg::CH_FULL - m4_ff[k]);
         n = $signed({4'b0, c4_ff, 17'b0}) + 37'(ph4_ff[k]) + 37'sd65536;
         if (n < 0) hl5_in[k] = 16'd0;
         else if (n[36:17] > 20'h0FFFF) hl5_in[k] = 16'hFFFF;
         else hl5_in[k] = n[32:17];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res_in[k] = (f5_ff == rhc_pkg::FUNC_HSL2RGB) ? hl5_ff[k]
                   : rhc_pkg::div_full_round({2'b0, pv5_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f1_ff      <= func;
         fn1_ff     <= fn1_in;
         span1_ff   <= span1_in;
         b1_ff      <= chan_b;
         c1_ff      <= chan_c;
         f2_ff      <= f1_ff;
         cs2_ff     <= cs2_in;
         pc2_ff     <= span1_ff * b1_ff;
         fn2_ff     <= fn1_ff;
         b2_ff      <= b1_ff;
         c2_ff      <= c1_ff;
         f3_ff      <= f2_ff;
         pm3_ff     <= pm3_in;
         chroma3_ff <= rhc_pkg::div_full_round({2'b0, pc2_ff});
         fn3_ff     <= fn2_ff;
         c3_ff      <= c2_ff;
         f4_ff      <= f3_ff;
         m4_ff      <= m4_in;
         ph4_ff     <= ph4_in;
         c4_ff      <= c3_ff;
         f5_ff      <= f4_ff;
         pv5_ff     <= pv5_in;
         hl5_ff     <= hl5_in;
         res_ff     <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: rtl/core/rgb_hsv_hsl_convert_core.sv
// Channel   Direction  Ports                        Contents
// req_      in         tvalid tready tdata tuser    pixel and conversion mode
// rsp_      out        tvalid tready tdata          converted pixel
//
// One word enters per cycle while req_tready is high.
// Hue and saturation ratios go through the 17-stage restoring divider.
// Reset clears the valid bits of the pipeline and of the output register.
// A stall on rsp_ freezes the pipeline only once its last stage holds a word.
module rgb_hsv_hsl_convert_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // chan_a, chan_b, chan_c
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // out_a, out_b, out_c
);

   localparam int L = rhc_pkg::PIPE_LEN;
   localparam int D = rhc_pkg::HSX_DELAY;

   logic [L-1:0] v_ff;
   logic         ce, load_h, hv_ff;
   logic [47:0]  hold_ff, result;

   rhc_pkg::func_type func_ff;
   logic [15:0] a_ff, b_ff, c_ff;

   logic [1:0][rhc_pkg::NUM_BITS-1:0] num;
   logic [1:0][rhc_pkg::DEN_BITS-1:0] den;
   logic [1:0][rhc_pkg::QUO_BITS-1:0] quo;
   rhc_pkg::div_tag_type tag, tag_out;
   logic [2:0][15:0] hsx_res;
   logic [2:0][15:0] dly_ff [D];
   logic [15:0] sat_out;

   assign load_h     = v_ff[L-1] & (~hv_ff | rsp_tready);
   assign ce         = ~v_ff[L-1] | load_h;
   assign req_tready = ce;
   assign rsp_tvalid = hv_ff;
   assign rsp_tdata  = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         hv_ff <= 1'b0;
      end else begin
         if (ce) v_ff <= {v_ff[L-2:0], req_tvalid};
         if (load_h) hv_ff <= 1'b1;
         else if (rsp_tready) hv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         func_ff <= rhc_pkg::func_type'(req_tuser);
         a_ff    <= req_tdata[15:0];
         b_ff    <= req_tdata[31:16];
         c_ff    <= req_tdata[47:32];
         dly_ff[0] <= hsx_res;
         for (int i = 1; i < D; i++) dly_ff[i] <= dly_ff[i-1];
      end
      if (load_h) hold_ff <= result;
   end

   rhc_rgb u_rgb (
      .clock  (clock),
      .ce     (ce),
      .func   (func_ff),
      .chan_a (a_ff),
      .chan_b (b_ff),
      .chan_c (c_ff),
      .num    (num),
      .den    (den),
      .tag    (tag)
   );

   rhc_div u_div (
      .clock   (clock),
      .ce      (ce),
      .num     (num),
      .den     (den),
      .tag     (tag),
      .quo     (quo),
      .tag_out (tag_out)
   );

   rhc_hsx u_hsx (
      .clock  (clock),
      .ce     (ce),
      .func   (func_ff),
      .chan_a (a_ff),
      .chan_b (b_ff),
      .chan_c (c_ff),
      .res    (hsx_res)
   );

   always_comb begin
      sat_out = (quo[1] > rhc_pkg::QUO_BITS'(rhc_pkg::CH_FULL)) ? rhc_pkg::CH_FULL
              : quo[1][15:0];
      if (tag_out.func == rhc_pkg::FUNC_RGB2HSV || tag_out.func == rhc_pkg::FUNC_RGB2HSL) begin
         result = {tag_out.val,
                   tag_out.sat_zero ? 16'd0 : sat_out,
                   tag_out.hue_zero ? 16'd0 : quo[0][15:0]};
      end else begin
         result = {dly_ff[D-1][2], dly_ff[D-1][1], dly_ff[D-1][0]};
      end
   end

endmodule

// File: rtl/core/rhc_check.sv
module rhc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled output");

endmodule

bind rgb_hsv_hsl_convert_core rhc_check u_rhc_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   typedef struct {
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
   } pixel_type;

   typedef struct {
      rhc_pkg::func_type func;
      pixel_type         pix;
      bit                fixed;
      pixel_type         want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   pixel_type   pending_pixels[$];
   int          error_count = 0;
   int          table_errors;
   int          pixels_sent;
   int          pixels_checked = 0;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_req;
   int          hold_seen;
   int          hold_cycles;
   stim_row_type stim_rows[$];

   rgb_hsv_hsl_convert_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #2 clock = ~clock;
      end
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic longint unsigned clip_full(longint unsigned v);
      return (v > 65535) ? 65535 : v;
   endfunction

   function automatic longint unsigned tri_level(longint unsigned hue, longint unsigned off);
      longint unsigned p;
      longint unsigned gap;
      longint unsigned fn;
      p = (6 * hue + off * 65536) % (6 * 65536);
      gap = (p > 3 * 65536) ? p - 3 * 65536 : 3 * 65536 - p;
      fn = (gap > 65536) ? gap - 65536 : 0;
      return (fn > 65536) ? 65536 : fn;
   endfunction

   function automatic pixel_type convert_pixel(rhc_pkg::func_type func, pixel_type pix);
      longint unsigned ra, gb, bc, mx, mn, d, sum, lim, hue, fn, cs, m, dev, span, chroma;
      longint          t, num;
      longint unsigned res[3];
      longint unsigned offs[3];
      pixel_type       o;
      offs = '{0, 4, 2};
      ra = pix.a;
      gb = pix.b;
      bc = pix.c;
      if (func == rhc_pkg::FUNC_RGB2HSV || func == rhc_pkg::FUNC_RGB2HSL) begin
         mx = ra; mn = ra;
         if (gb > mx) mx = gb;
         if (bc > mx) mx = bc;
         if (gb < mn) mn = gb;
         if (bc < mn) mn = bc;
         d = mx - mn;
         hue = 0;
         if (d != 0) begin
            if (ra >= gb && ra >= bc) begin
               t = longint'(gb) - longint'(bc);
               if (t < 0) t += 6 * longint'(d);
            end else if (gb >= bc) begin
               t = longint'(bc) - longint'(ra) + 2 * longint'(d);
            end else begin
               t = longint'(ra) - longint'(gb) + 4 * longint'(d);
            end
            hue = ((longint'(t) * 131072 + 6 * d) / (12 * d)) & 65535;
         end
         res[0] = hue;
         if (func == rhc_pkg::FUNC_RGB2HSV) begin
            res[1] = (mx == 0) ? 0 : clip_full(round_div(d * 65535, mx));
            res[2] = mx;
         end else begin
            sum = mx + mn;
            lim = (sum < 2 * 65535 - sum) ? sum : 2 * 65535 - sum;
            res[1] = (lim == 0) ? 0 : clip_full(round_div(d * 65535, lim));
            res[2] = clip_full((sum + 1) >> 1);
         end
      end else if (func == rhc_pkg::FUNC_HSV2RGB) begin
         for (int k = 0; k < 3; k++) begin
            fn = tri_level(ra, offs[k]);
            cs = clip_full((fn * 65535 + 32768) >> 16);
            m = clip_full(round_div(gb * (65535 - cs), 65535));
            res[k] = clip_full(round_div(bc * (65535 - m), 65535));
         end
      end else begin
         dev = (2 * bc > 65535) ? 2 * bc - 65535 : 65535 - 2 * bc;
         span = (dev > 65535) ? 0 : 65535 - dev;
         chroma = clip_full(round_div(span * gb, 65535));
         for (int k = 0; k < 3; k++) begin
            fn = tri_level(ra, offs[k]);
            num = longint'(bc << 17) + longint'(chroma) * (2 * longint'(fn) - 65536) + 65536;
            res[k] = (num < 0) ? 0 : clip_full(longint'(num) >>> 17);
         end
      end
      o.a = res[0][15:0];
      o.b = res[1][15:0];
      o.c = res[2][15:0];
      return o;
   endfunction

   task automatic add_row(rhc_pkg::func_type func, int a, int b, int c, bit fixed = 0,
                          int wa = 0, int wb = 0, int wc = 0);
      stim_row_type row;
      row.func = func;
      row.pix = '{a[15:0], b[15:0], c[15:0]};
      row.fixed = fixed;
      row.want = '{wa[15:0], wb[15:0], wc[15:0]};
      stim_rows.push_back(row);
   endtask

   task automatic send_pixel(rhc_pkg::func_type func, pixel_type pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {pix.c, pix.b, pix.a};
      pending_pixels.push_back(convert_pixel(func, pix));
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pixels_sent++;
   endtask

   task automatic send_random(int count);
      pixel_type         pix;
      rhc_pkg::func_type func;
      int                mode;
      for (int i = 0; i < count; i++) begin
         func = rhc_pkg::func_type'($urandom_range(3));
         mode = $urandom_range(9);
         pix.a = 16'($urandom);
         pix.b = 16'($urandom);
         pix.c = 16'($urandom);
         if (mode == 0) begin
            pix.b = pix.a;
            pix.c = pix.a;
         end else if (mode == 1) begin
            pix.a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            pix.c = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         end else if (mode == 2) begin
            pix.b = 16'(pix.a + $urandom_range(3));
         end
         send_pixel(func, pix);
      end
   endtask

   task automatic drain_all;
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_seen   <= 0;
         hold_cycles <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen   <= hold_req;
         hold_cycles <= 200;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32]};
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.a !== want.a || got.b !== want.b || got.c !== want.c) begin
               $display("%0t: mismatch, expected %h %h %h, actual %h %h %h", $time,
                        want.a, want.b, want.c, got.a, got.b, got.c);
               error_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      pixel_type    pred;
      int           wait_cycles;
      table_errors = 0;
      pixels_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = rhc_pkg::FUNC_RGB2HSV;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row(rhc_pkg::FUNC_RGB2HSV, 0, 0, 0, 1, 0, 0, 0);
      add_row(rhc_pkg::FUNC_RGB2HSV, 65535, 65535, 65535, 1, 0, 0, 65535);
      add_row(rhc_pkg::FUNC_RGB2HSV, 65535, 0, 0, 1, 0, 65535, 65535);
      add_row(rhc_pkg::FUNC_RGB2HSV, 0, 65535, 0);
      add_row(rhc_pkg::FUNC_RGB2HSV, 0, 0, 65535);
      add_row(rhc_pkg::FUNC_RGB2HSV, 65535, 0, 1);
      add_row(rhc_pkg::FUNC_RGB2HSV, 65535, 65535, 0);
      add_row(rhc_pkg::FUNC_RGB2HSV, 1234, 1234, 1234, 1, 0, 0, 1234);
      add_row(rhc_pkg::FUNC_HSV2RGB, 0, 0, 0, 1, 0, 0, 0);
      add_row(rhc_pkg::FUNC_HSV2RGB, 0, 65535, 65535, 1, 65535, 0, 0);
      add_row(rhc_pkg::FUNC_HSV2RGB, 65535, 65535, 65535);
      add_row(rhc_pkg::FUNC_HSV2RGB, 21845, 65535, 65535);
      add_row(rhc_pkg::FUNC_HSV2RGB, 43690, 32768, 40000);
      add_row(rhc_pkg::FUNC_RGB2HSL, 0, 0, 0, 1, 0, 0, 0);
      add_row(rhc_pkg::FUNC_RGB2HSL, 65535, 65535, 65535, 1, 0, 0, 65535);
      add_row(rhc_pkg::FUNC_RGB2HSL, 65535, 0, 0);
      add_row(rhc_pkg::FUNC_RGB2HSL, 0, 65535, 65535);
      add_row(rhc_pkg::FUNC_RGB2HSL, 100, 200, 65535);
      add_row(rhc_pkg::FUNC_HSL2RGB, 0, 0, 0, 1, 0, 0, 0);
      add_row(rhc_pkg::FUNC_HSL2RGB, 0, 65535, 65535, 1, 65535, 65535, 65535);
      add_row(rhc_pkg::FUNC_HSL2RGB, 0, 65535, 32768);
      add_row(rhc_pkg::FUNC_HSL2RGB, 65535, 65535, 32767);
      add_row(rhc_pkg::FUNC_HSL2RGB, 30000, 12345, 50000);

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.fixed) begin
            pred = convert_pixel(row.func, row.pix);
            if (pred.a !== row.want.a || pred.b !== row.want.b || pred.c !== row.want.c) begin
               $display("%0t: mismatch, expected %h %h %h, actual %h %h %h", $time,
                        row.want.a, row.want.b, row.want.c, pred.a, pred.b, pred.c);
               table_errors++;
            end
         end
         send_pixel(row.func, row.pix);
      end
      drain_all();

      send_random(200);
      send_idle_pct = 73;
      send_random(150);
      send_idle_pct = 0;
      recv_stall_pct = 73;
      send_random(150);
      send_idle_pct = 34;
      recv_stall_pct = 34;
      send_random(150);
      drain_all();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_req <= 1;
      send_random(150);
      drain_all();

      wait_cycles = 0;
      while (pending_pixels.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (rhc_pkg::PIPE_LEN + 10) @(posedge clock);
      $display("Sent %0d pixels in all four modes, checked %0d converted pixels,",
               pixels_sent, pixels_checked);
      $display("with idle sender, stalled receiver and a long output hold.");
      if (error_count == 0 && table_errors == 0 && pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
